>>> sv/sgsg_pkg.sv
// Shared types, constants and the glyph segment ROM of the segment glyph span generator.
// Used by every module of the block; depends on nothing.
package sgsg_pkg;

	// Segment indexes in drawing order.
	localparam logic [4:0] SEG_TL   = 5'd0;
	localparam logic [4:0] SEG_TR   = 5'd1;
	localparam logic [4:0] SEG_ML   = 5'd2;
	localparam logic [4:0] SEG_MR   = 5'd3;
	localparam logic [4:0] SEG_BL   = 5'd4;
	localparam logic [4:0] SEG_BR   = 5'd5;
	localparam logic [4:0] SEG_UL   = 5'd6;
	localparam logic [4:0] SEG_LL   = 5'd7;
	localparam logic [4:0] SEG_UR   = 5'd8;
	localparam logic [4:0] SEG_LR   = 5'd9;
	localparam logic [4:0] SEG_UM   = 5'd10;
	localparam logic [4:0] SEG_LM   = 5'd11;
	localparam logic [4:0] SEG_DUL  = 5'd12;
	localparam logic [4:0] SEG_DUR  = 5'd13;
	localparam logic [4:0] SEG_DLL  = 5'd14;
	localparam logic [4:0] SEG_DLR  = 5'd15;
	localparam logic [4:0] SEG_DOTL = 5'd16;
	localparam logic [4:0] SEG_DOTM = 5'd17;
	localparam logic [4:0] SEG_LAST = SEG_DOTM;

	// Segment mask bits.
	localparam logic [17:0] K_TL   = 18'(1) << SEG_TL;
	localparam logic [17:0] K_TR   = 18'(1) << SEG_TR;
	localparam logic [17:0] K_ML   = 18'(1) << SEG_ML;
	localparam logic [17:0] K_MR   = 18'(1) << SEG_MR;
	localparam logic [17:0] K_BL   = 18'(1) << SEG_BL;
	localparam logic [17:0] K_BR   = 18'(1) << SEG_BR;
	localparam logic [17:0] K_UL   = 18'(1) << SEG_UL;
	localparam logic [17:0] K_LL   = 18'(1) << SEG_LL;
	localparam logic [17:0] K_UR   = 18'(1) << SEG_UR;
	localparam logic [17:0] K_LR   = 18'(1) << SEG_LR;
	localparam logic [17:0] K_UM   = 18'(1) << SEG_UM;
	localparam logic [17:0] K_LM   = 18'(1) << SEG_LM;
	localparam logic [17:0] K_DUL  = 18'(1) << SEG_DUL;
	localparam logic [17:0] K_DUR  = 18'(1) << SEG_DUR;
	localparam logic [17:0] K_DLL  = 18'(1) << SEG_DLL;
	localparam logic [17:0] K_DLR  = 18'(1) << SEG_DLR;
	localparam logic [17:0] K_DOTL = 18'(1) << SEG_DOTL;
	localparam logic [17:0] K_DOTM = 18'(1) << SEG_DOTM;

	// Character range of the ROM and the substitute for codes outside it.
	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST  = 8'h5A;
	localparam logic [7:0] CHAR_SUBST = 8'h3F;
	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_Z    = 8'h7A;
	localparam logic [7:0] CASE_FOLD  = 8'h20;

	// Configuration register indexes.
	localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
	localparam logic [1:0] REG_STROKE_WIDTH = 2'd2;

	// Quotient bits produced by the diagonal divider.
	localparam int DIV_QBITS = 12;

	// One classified character on its way to the span sequencer.
	typedef struct packed {
		logic [17:0]        mask;
		logic signed [11:0] ox;
		logic [6:0]         gy;
	} sgsg_item_t;

	// Segment mask of a character, after case folding and substitution.
	function automatic logic [17:0] glyph_mask(input logic [7:0] code);
		logic [7:0]  c;
		logic [17:0] m;
		c = code;
		if (c >= LOWER_A && c <= LOWER_Z)
			c = c - CASE_FOLD;
		if (c < CHAR_FIRST || c > CHAR_LAST)
			c = CHAR_SUBST;
		unique case (c)
			8'h20: m = '0;
			8'h21: m = K_UM | K_DOTL;
			8'h22: m = K_UM;
			8'h23: m = K_ML | K_MR | K_UM | K_LM;
			8'h24: m = K_TL | K_TR | K_UL | K_ML | K_MR | K_LR | K_BL | K_BR | K_UM | K_LM;
			8'h25: m = K_UL | K_LR | K_DUR | K_DLL;
			8'h26: m = K_TL | K_UL | K_ML | K_LL | K_BL | K_BR | K_DLR;
			8'h27: m = K_UM;
			8'h28: m = K_TL | K_UL | K_LL | K_BL;
			8'h29: m = K_TR | K_UR | K_LR | K_BR;
			8'h2A: m = K_ML | K_MR | K_UM | K_LM | K_DUL | K_DUR | K_DLL | K_DLR;
			8'h2B: m = K_ML | K_MR | K_UM | K_LM;
			8'h2C: m = K_DOTL;
			8'h2D: m = K_ML | K_MR;
			8'h2E: m = K_DOTL;
			8'h2F: m = K_DUR | K_DLL;
			8'h30: m = K_TL | K_TR | K_UL | K_UR | K_LL | K_LR | K_BL | K_BR;
			8'h31: m = K_UR | K_LR;
			8'h32: m = K_TL | K_TR | K_UR | K_ML | K_MR | K_LL | K_BL | K_BR;
			8'h33: m = K_TL | K_TR | K_UR | K_MR | K_LR | K_BL | K_BR;
			8'h34: m = K_UL | K_UR | K_ML | K_MR | K_LR;
			8'h35: m = K_TL | K_TR | K_UL | K_ML | K_MR | K_LR | K_BL | K_BR;
			8'h36: m = K_TL | K_TR | K_UL | K_ML | K_MR | K_LL | K_LR | K_BL | K_BR;
			8'h37: m = K_TL | K_TR | K_UR | K_LR;
			8'h38: m = K_TL | K_TR | K_UL | K_UR | K_ML | K_MR | K_LL | K_LR | K_BL | K_BR;
			8'h39: m = K_TL | K_TR | K_UL | K_UR | K_ML | K_MR | K_LR | K_BL | K_BR;
			8'h3A: m = K_DOTL | K_DOTM;
			8'h3B: m = K_DOTL | K_DOTM;
			8'h3C: m = K_DUR | K_DLR;
			8'h3D: m = K_ML | K_MR | K_BL | K_BR;
			8'h3E: m = K_DUL | K_DLL;
			8'h3F: m = K_TL | K_TR | K_UR | K_MR | K_LM | K_DOTL;
			8'h40: m = K_TL | K_TR | K_UL | K_LL | K_BL | K_BR | K_UR | K_MR | K_LM;
			8'h41: m = K_TL | K_TR | K_UL | K_UR | K_ML | K_MR | K_LL | K_LR;
			8'h42: m = K_TL | K_TR | K_UR | K_LR | K_MR | K_BL | K_BR | K_UM | K_LM;
			8'h43: m = K_TL | K_TR | K_UL | K_LL | K_BL | K_BR;
			8'h44: m = K_TL | K_TR | K_UR | K_LR | K_BL | K_BR | K_UM | K_LM;
			8'h45: m = K_TL | K_TR | K_UL | K_LL | K_ML | K_BL | K_BR;
			8'h46: m = K_TL | K_TR | K_UL | K_LL | K_ML;
			8'h47: m = K_TL | K_TR | K_UL | K_LL | K_LR | K_MR | K_BL | K_BR;
			8'h48: m = K_UL | K_LL | K_UR | K_LR | K_ML | K_MR;
			8'h49: m = K_TL | K_TR | K_BL | K_BR | K_UM | K_LM;
			8'h4A: m = K_TR | K_UR | K_LR | K_LL | K_BL | K_BR;
			8'h4B: m = K_UL | K_LL | K_ML | K_DUR | K_DLR;
			8'h4C: m = K_UL | K_LL | K_BL | K_BR;
			8'h4D: m = K_UL | K_LL | K_UR | K_LR | K_DUL | K_DUR;
			8'h4E: m = K_UL | K_LL | K_UR | K_LR | K_DUL | K_DLR;
			8'h4F: m = K_TL | K_TR | K_UL | K_UR | K_LL | K_LR | K_BL | K_BR;
			8'h50: m = K_TL | K_TR | K_UL | K_LL | K_UR | K_ML | K_MR;
			8'h51: m = K_TL | K_TR | K_UL | K_UR | K_LL | K_LR | K_BL | K_BR | K_DLR;
			8'h52: m = K_TL | K_TR | K_UL | K_LL | K_UR | K_ML | K_MR | K_DLR;
			8'h53: m = K_TL | K_TR | K_UL | K_ML | K_MR | K_LR | K_BL | K_BR;
			8'h54: m = K_TL | K_TR | K_UM | K_LM;
			8'h55: m = K_UL | K_LL | K_UR | K_LR | K_BL | K_BR;
			8'h56: m = K_UL | K_UR | K_LM;
			8'h57: m = K_UL | K_LL | K_UR | K_LR | K_DLL | K_DLR;
			8'h58: m = K_DUL | K_DUR | K_DLL | K_DLR;
			8'h59: m = K_UL | K_UR | K_LM;
			8'h5A: m = K_TL | K_TR | K_DUR | K_DLL | K_BL | K_BR;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

>>> sv/sgsg_front.sv
// Front end: takes characters, folds and looks up the segment mask, and finds the glyph row.
// Depends on sgsg_pkg.
module sgsg_front import sgsg_pkg::*; (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic signed [11:0] glyph_x,
	input  logic signed [11:0] scan_row,
	input  logic signed [11:0] text_top,
	input  logic [6:0]         glyph_height,
	output logic               q_valid,
	input  logic               q_ready,
	output sgsg_item_t         q_item
);

	logic signed [12:0] gy;
	logic signed [12:0] hlim;
	logic               in_cell;

	// Glyph row and whether the scan row falls inside the cell.
	assign gy      = {scan_row[11], scan_row} - {text_top[11], text_top};
	assign hlim    = {6'b000000, glyph_height};
	assign in_cell = !gy[12] && (gy < hlim);

	// A transfer here is a push into the queue.
	assign in_ready      = q_ready;
	assign q_valid       = in_valid;
	assign q_item.mask   = in_cell ? glyph_mask(char_code) : '0;
	assign q_item.ox     = glyph_x;
	assign q_item.gy     = gy[6:0];

endmodule

>>> sv/sgsg_queue.sv
// Two-entry queue of classified characters between the front end and the span sequencer.
// Depends on sgsg_pkg.
module sgsg_queue import sgsg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  sgsg_item_t push_item,
	output logic       pop_valid,
	input  logic       pop_ready,
	output sgsg_item_t pop_item
);

	sgsg_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> sv/sgsg_div.sv
// Restoring divider for diagonal stroke centers, one quotient bit per cycle, truncating.
// Depends on sgsg_pkg for the quotient length.
module sgsg_div import sgsg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [23:0] num,
	input  logic signed [9:0]  den,
	output logic               busy,
	output logic               done,
	output logic signed [12:0] quo
);

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [9:0]  rem_q;
	logic [11:0] low_q;
	logic [9:0]  dmag_q;
	logic        neg_q;
	logic [23:0] nmag;
	logic [9:0]  dmag;
	logic [10:0] remsh;
	logic [10:0] remsub;
	logic        ge;

	// Operand magnitudes. The quotient magnitude stays below 2^11, so the
	// upper numerator bits start out below the divisor.
	assign nmag   = num[23] ? 24'(-num) : num;
	assign dmag   = den[9] ? 10'(-den) : den;
	assign remsh  = {rem_q, low_q[11]};
	assign remsub = remsh - {1'b0, dmag_q};
	assign ge     = (remsh >= {1'b0, dmag_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'(DIV_QBITS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd0)
				busy_q <= 1'b0;
		end
	end

	// Shift and subtract datapath; the quotient shifts into the low word.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= nmag[21:12];
			low_q  <= nmag[11:0];
			dmag_q <= dmag;
			neg_q  <= num[23] ^ den[9];
		end else if (busy_q) begin
			rem_q <= ge ? remsub[9:0] : remsh[9:0];
			low_q <= {low_q[10:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == 4'd0);
	assign quo  = neg_q ? -$signed({1'b0, low_q}) : $signed({1'b0, low_q});

endmodule

>>> sv/sgsg_back.sv
// Span sequencer: walks the 18 segments of one character and emits the covered spans.
// Depends on sgsg_pkg and sgsg_div.
module sgsg_back import sgsg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  sgsg_item_t         item,
	input  logic [6:0]         glyph_width,
	input  logic [6:0]         glyph_height,
	input  logic [4:0]         stroke_width,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] span_start,
	output logic signed [16:0] span_end,
	output logic [4:0]         segment_id,
	output logic               has_span,
	output logic               last_of_glyph
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEG  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_DFIN = 3'd3;
	localparam logic [2:0] ST_END  = 3'd4;

	logic [2:0]         st_q, st_d;
	logic [4:0]         seg_q;
	logic [17:0]        mask_q;
	logic signed [11:0] ox_q;
	logic [6:0]         gy_q;
	logic               pend_v_q;
	logic signed [16:0] pend_a_q, pend_b_q;
	logic [4:0]         pend_id_q;
	logic               out_valid_q;
	logic signed [16:0] out_a_q, out_b_q;
	logic [4:0]         out_id_q;
	logic               out_has_q, out_last_q;

	logic signed [9:0]  w_s, h_s, t_s, xm_s, ym_s, ht_s, t1_s, gy_s;
	logic signed [9:0]  ylo, yhi, xa, xb, ax, ay, bx, by;
	logic signed [9:0]  d_lo, d_hi, dx, dgy, den;
	logic signed [19:0] prod;
	logic signed [23:0] num;
	logic signed [16:0] ox17, xa17, xb17, ax17, t8, quo17;
	logic signed [16:0] bar_a, bar_b, d_c, d_a, d_b, cand_a, cand_b;
	logic signed [12:0] quo;
	logic               lit, is_diag, bar_hit, d_hit, cand_ok;
	logic               take_try, seg_adv, div_start, div_busy, div_done;
	logic               pend_load, pend_clr, push, push_last, out_free;

	// Cell geometry from the configuration.
	assign w_s  = {3'b000, glyph_width};
	assign h_s  = {3'b000, glyph_height};
	assign t_s  = {5'b00000, stroke_width};
	assign xm_s = {4'b0000, glyph_width[6:1]};
	assign ym_s = {4'b0000, glyph_height[6:1]};
	assign ht_s = {6'b000000, stroke_width[4:1]};
	assign t1_s = {9'b000000000, stroke_width[0]};
	assign gy_s = {3'b000, gy_q};

	// Row band and column extent of the current segment; end points for diagonals.
	always_comb begin
		ylo = '0;
		yhi = '0;
		xa  = '0;
		xb  = '0;
		ax  = '0;
		ay  = '0;
		bx  = xm_s;
		by  = ym_s;
		unique case (seg_q)
			SEG_TL:   begin yhi = t_s; xb = xm_s + ht_s; end
			SEG_TR:   begin yhi = t_s; xa = xm_s - ht_s; xb = w_s; end
			SEG_ML:   begin
				ylo = ym_s - ht_s; yhi = ym_s - ht_s + t_s; xb = xm_s + ht_s;
			end
			SEG_MR:   begin
				ylo = ym_s - ht_s; yhi = ym_s - ht_s + t_s; xa = xm_s - ht_s; xb = w_s;
			end
			SEG_BL:   begin ylo = h_s - t_s; yhi = h_s; xb = xm_s + ht_s; end
			SEG_BR:   begin ylo = h_s - t_s; yhi = h_s; xa = xm_s - ht_s; xb = w_s; end
			SEG_UL:   begin yhi = ym_s + ht_s; xb = t_s; end
			SEG_LL:   begin ylo = ym_s - ht_s; yhi = h_s; xb = t_s; end
			SEG_UR:   begin yhi = ym_s + ht_s; xa = w_s - t_s; xb = w_s; end
			SEG_LR:   begin ylo = ym_s - ht_s; yhi = h_s; xa = w_s - t_s; xb = w_s; end
			SEG_UM:   begin
				yhi = ym_s + ht_s; xa = xm_s - ht_s; xb = xm_s - ht_s + t_s;
			end
			SEG_LM:   begin
				ylo = ym_s - ht_s; yhi = h_s; xa = xm_s - ht_s; xb = xm_s - ht_s + t_s;
			end
			SEG_DUL:  begin ax = ht_s; ay = ht_s; end
			SEG_DUR:  begin ax = w_s - ht_s; ay = ht_s; end
			SEG_DLL:  begin ax = ht_s; ay = h_s - ht_s; end
			SEG_DLR:  begin ax = w_s - ht_s; ay = h_s - ht_s; end
			SEG_DOTL: begin
				ylo = h_s - t_s; yhi = h_s; xa = xm_s - ht_s; xb = xm_s + ht_s + t1_s;
			end
			SEG_DOTM: begin
				ylo = ym_s - ht_s; yhi = ym_s - ht_s + t_s;
				xa = xm_s - ht_s; xb = xm_s + ht_s + t1_s;
			end
			default:  begin end
		endcase
	end

	// Bar coverage in sixteenth pixels.
	assign lit     = mask_q[seg_q];
	assign is_diag = (seg_q >= SEG_DUL) && (seg_q <= SEG_DLR);
	assign bar_hit = (gy_s >= ylo) && (gy_s < yhi);
	assign ox17    = {{5{ox_q[11]}}, ox_q};
	assign xa17    = {{7{xa[9]}}, xa};
	assign xb17    = {{7{xb[9]}}, xb};
	assign bar_a   = (ox17 + xa17) <<< 4;
	assign bar_b   = (ox17 + xb17) <<< 4;

	// Diagonal: row test and the product that feeds the divider.
	assign d_lo  = (ay < by) ? ay : by;
	assign d_hi  = (ay < by) ? by : ay;
	assign d_hit = (gy_s >= d_lo) && (gy_s < d_hi) && (ay != by);
	assign dx    = bx - ax;
	assign dgy   = gy_s - ay;
	assign den   = by - ay;
	assign prod  = dx * dgy;
	assign num   = {prod, 4'b0000};

	sgsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	// Diagonal span around the truncated center.
	assign ax17  = {{7{ax[9]}}, ax};
	assign quo17 = {{4{quo[12]}}, quo};
	assign t8    = {9'b000000000, stroke_width, 3'b000};
	assign d_c   = ((ox17 + ax17) <<< 4) + quo17;
	assign d_a   = d_c - t8;
	assign d_b   = d_c + t8;

	assign cand_a  = (st_q == ST_DFIN) ? d_a : bar_a;
	assign cand_b  = (st_q == ST_DFIN) ? d_b : bar_b;
	assign cand_ok = (st_q == ST_DFIN) ? (d_b > d_a) : (bar_hit && (bar_b > bar_a));

	assign out_free = !out_valid_q || out_ready;

	// Sequencer. One span is held back so the last one can be marked.
	always_comb begin
		st_d       = st_q;
		item_ready = 1'b0;
		take_try   = 1'b0;
		seg_adv    = 1'b0;
		div_start  = 1'b0;
		pend_load  = 1'b0;
		pend_clr   = 1'b0;
		push       = 1'b0;
		push_last  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid)
					st_d = ST_SEG;
			end
			ST_SEG: begin
				if (!lit) begin
					seg_adv = 1'b1;
				end else if (is_diag) begin
					if (d_hit) begin
						div_start = 1'b1;
						st_d      = ST_DIV;
					end else begin
						seg_adv = 1'b1;
					end
				end else begin
					take_try = 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done)
					st_d = ST_DFIN;
			end
			ST_DFIN: begin
				take_try = 1'b1;
			end
			ST_END: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					pend_clr  = 1'b1;
					st_d      = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
		if (take_try) begin
			if (!cand_ok) begin
				seg_adv = 1'b1;
			end else if (!pend_v_q || out_free) begin
				push      = pend_v_q;
				pend_load = 1'b1;
				seg_adv   = 1'b1;
			end
		end
		if (seg_adv)
			st_d = (seg_q == SEG_LAST) ? ST_END : ST_SEG;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			seg_q       <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_IDLE)
				seg_q <= '0;
			else if (seg_adv)
				seg_q <= (seg_q == SEG_LAST) ? 5'd0 : seg_q + 5'd1;
			if (pend_load)
				pend_v_q <= 1'b1;
			else if (pend_clr)
				pend_v_q <= 1'b0;
			out_valid_q <= push || (out_valid_q && !out_ready);
		end
	end

	// Item, held span and output registers.
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			mask_q <= item.mask;
			ox_q   <= item.ox;
			gy_q   <= item.gy;
		end
		if (pend_load) begin
			pend_a_q  <= cand_a;
			pend_b_q  <= cand_b;
			pend_id_q <= seg_q;
		end
		if (push) begin
			out_a_q    <= pend_v_q ? pend_a_q : '0;
			out_b_q    <= pend_v_q ? pend_b_q : '0;
			out_id_q   <= pend_v_q ? pend_id_q : '0;
			out_has_q  <= pend_v_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign span_start    = out_a_q;
	assign span_end      = out_b_q;
	assign segment_id    = out_id_q;
	assign has_span      = out_has_q;
	assign last_of_glyph = out_last_q;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> !pend_v_q)
		else $error("held span left over between characters");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result written over an untaken result");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> div_busy)
		else $error("waiting on an idle divider");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_last |=> st_q == ST_IDLE && !pend_v_q)
		else $error("character not closed after its last result");

endmodule

>>> sv/segment_glyph_span_generator_unit.sv
// Top level of the segment glyph span generator: configuration registers, front end,
// queue and span sequencer. Depends on sgsg_pkg, sgsg_front, sgsg_queue, sgsg_back.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    char_code, glyph_x, scan_row, text_top
//  out      output     out_valid/out_ready  span_start, span_end, segment_id, has_span,
//                                           last_of_glyph
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// In the span sequencer a character is loaded, its segments are walked in order and it is
// closed; each diagonal that crosses the row also waits on the serial divider.
// The front end and a two-entry queue take the next characters while one is in work.
// Reset clears control state and loads width 16, height 22, stroke 3.
// A stalled output holds the sequencer only when it has a further result to write
// while the previous one is still untaken.
module segment_glyph_span_generator_unit import sgsg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic signed [11:0] glyph_x,
	input  logic signed [11:0] scan_row,
	input  logic signed [11:0] text_top,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] span_start,
	output logic signed [16:0] span_end,
	output logic [4:0]         segment_id,
	output logic               has_span,
	output logic               last_of_glyph,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	logic [6:0] glyph_width_q;
	logic [6:0] glyph_height_q;
	logic [4:0] stroke_width_q;
	logic       fq_valid, fq_ready, qb_valid, qb_ready;
	sgsg_item_t fq_item, qb_item;

	// Configuration registers; a transfer to an unused index is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q  <= 7'd16;
			glyph_height_q <= 7'd22;
			stroke_width_q <= 5'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data;
				REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data;
				REG_STROKE_WIDTH: stroke_width_q <= cfg_data[4:0];
				default: begin end
			endcase
		end
	end

	sgsg_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.glyph_x      (glyph_x),
		.scan_row     (scan_row),
		.text_top     (text_top),
		.glyph_height (glyph_height_q),
		.q_valid      (fq_valid),
		.q_ready      (fq_ready),
		.q_item       (fq_item)
	);

	sgsg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	sgsg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (qb_valid),
		.item_ready    (qb_ready),
		.item          (qb_item),
		.glyph_width   (glyph_width_q),
		.glyph_height  (glyph_height_q),
		.stroke_width  (stroke_width_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.span_start    (span_start),
		.span_end      (span_end),
		.segment_id    (segment_id),
		.has_span      (has_span),
		.last_of_glyph (last_of_glyph)
	);

endmodule
